>>> sv/csbuf_pkg.sv
`default_nettype none
package csbuf_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int USE_BITS  = 4;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int TABLE_W   = 8;
  localparam int PAGE_W    = 16;

  localparam logic [USE_BITS-1:0] USE_MAX = {USE_BITS{1'b1}};
  localparam logic [CNT_W-1:0]    SLOTS_RESET = CNT_W'(MAX_SLOTS);

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take a request this cycle
    logic step;      // visit the slot under the sweep pointer: claim it or age it and move on
    logic out_load;  // capture a result in the output register
  } csbuf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;  // incoming request misses on a full, not fully pinned buffer
    logic victim;      // slot under the sweep pointer can be replaced
  } csbuf_stat_t;

endpackage
`default_nettype wire

>>> sv/clock_sweep_page_buffer.sv
// Page buffer slot manager with clock-sweep replacement. Each request names a
// page by table id and page index, or releases the pin of one slot. A release,
// a hit, a fill of an empty slot and an all-pinned failure are resolved in the
// cycle the request is taken and show on the output port in the next cycle. A
// miss on a full buffer starts the clock hand, which visits one slot per clock,
// aging use counts, until it finds an unpinned slot with a zero count; it
// visits at most 2^USE_BITS times the active slot count of slots (256 with
// sixteen active slots), since the only unpinned slot may sit just behind
// the hand with a full use count. Each sweep step visits a single slot, and
// a sweep step waits while an earlier result is held stalled in the output
// register. One request is in work at a time; the next one is taken when
// the output register is empty or in the cycle its result is taken. The user
// must write slots_in_use only while the block is idle; the block itself does
// not enforce it. 0 behaves as 1 and values above the slot count behave as
// the slot count.
`default_nettype none
module clock_sweep_page_buffer import csbuf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CNT_W-1:0]   cfg_wdata_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [TABLE_W-1:0] table_id_i,
  input  wire logic [PAGE_W-1:0]  page_index_i,
  input  wire logic [SLOT_W-1:0]  release_slot_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SLOT_W-1:0]       slot_o,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic [TABLE_W-1:0]      evicted_table_o,
  output logic [PAGE_W-1:0]       evicted_page_o,
  output logic                    failed_o
);

  csbuf_cmd_t  cmd;
  csbuf_stat_t stat;

  // sequencing: request intake, sweep stepping, output register handshake
  csbuf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // slot state, parallel lookup, sweep pointer and result register
  csbuf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .table_id_i      (table_id_i),
    .page_index_i    (page_index_i),
    .release_slot_i  (release_slot_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .slot_o          (slot_o),
    .hit_o           (hit_o),
    .evicted_o       (evicted_o),
    .evicted_table_o (evicted_table_o),
    .evicted_page_o  (evicted_page_o),
    .failed_o        (failed_o)
  );

endmodule
`default_nettype wire

>>> sv/csbuf_dp.sv
`default_nettype none
module csbuf_dp import csbuf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CNT_W-1:0]   cfg_wdata_i,
  input  wire logic               command_i,
  input  wire logic [TABLE_W-1:0] table_id_i,
  input  wire logic [PAGE_W-1:0]  page_index_i,
  input  wire logic [SLOT_W-1:0]  release_slot_i,
  input  wire csbuf_cmd_t         cmd_i,
  output csbuf_stat_t             stat_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic [TABLE_W-1:0]      evicted_table_o,
  output logic [PAGE_W-1:0]       evicted_page_o,
  output logic                    failed_o
);

  logic [CNT_W-1:0]    slots_in_use_q;
  logic [MAX_SLOTS-1:0] valid_q;
  logic [MAX_SLOTS-1:0] pinned_q;
  logic [USE_BITS-1:0] use_q [MAX_SLOTS];
  logic [TABLE_W-1:0]  table_q [MAX_SLOTS];
  logic [PAGE_W-1:0]   page_q [MAX_SLOTS];
  logic [SLOT_W-1:0]   hand_q, hand_d;
  logic [SLOT_W-1:0]   pos_q;
  logic [TABLE_W-1:0]  req_table_q;
  logic [PAGE_W-1:0]   req_page_q;

  logic [SLOT_W-1:0]   slot_q;
  logic                hit_q, evicted_q, failed_q;
  logic [TABLE_W-1:0]  ev_table_q;
  logic [PAGE_W-1:0]   ev_page_q;

  logic [CNT_W-1:0]     n_eff;
  logic [MAX_SLOTS-1:0] match, empty, unpinned;
  logic                 hit_any, empty_any, any_free;
  logic [SLOT_W-1:0]    hit_idx, fill_idx, hand_start, pos_next;
  logic                 is_req, rel_ok, victim;

  always_comb begin
    if (slots_in_use_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (slots_in_use_q > CNT_W'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = slots_in_use_q;
    end
  end

  always_comb begin
    hit_idx  = '0;
    fill_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match[i]    = (CNT_W'(i) < n_eff) && valid_q[i] &&
                    (table_q[i] == table_id_i) && (page_q[i] == page_index_i);
      empty[i]    = (CNT_W'(i) < n_eff) && !valid_q[i];
      unpinned[i] = (CNT_W'(i) < n_eff) && !pinned_q[i];
    end
    // lowest index wins
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (empty[i]) begin
        fill_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_any    = |match;
  assign empty_any  = |empty;
  assign any_free   = |unpinned;
  assign is_req     = (command_i == CMD_REQUEST);
  assign rel_ok     = (CNT_W'(release_slot_i) < CNT_W'(MAX_SLOTS));
  assign hand_start = (CNT_W'(hand_q) < n_eff) ? hand_q : '0;
  assign pos_next   = ((CNT_W'(pos_q) + CNT_W'(1)) < n_eff) ? pos_q + SLOT_W'(1) : '0;
  assign victim     = !pinned_q[pos_q] && (use_q[pos_q] == '0);

  assign stat_o.need_sweep = is_req && !hit_any && !empty_any && any_free;
  assign stat_o.victim     = victim;

  // slot control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SLOTS_RESET;
      valid_q        <= '0;
      pinned_q       <= '0;
      hand_q         <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        use_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        slots_in_use_q <= cfg_wdata_i;
      end
      hand_q <= hand_d;
      if (cmd_i.accept) begin
        if (!is_req) begin
          if (rel_ok) begin
            pinned_q[release_slot_i] <= 1'b0;
          end
        end else if (hit_any) begin
          pinned_q[hit_idx] <= 1'b1;
          if (use_q[hit_idx] != USE_MAX) begin
            use_q[hit_idx] <= use_q[hit_idx] + USE_BITS'(1);
          end
        end else if (empty_any) begin
          valid_q[fill_idx]  <= 1'b1;
          pinned_q[fill_idx] <= 1'b1;
          use_q[fill_idx]    <= USE_BITS'(1);
        end
      end else if (cmd_i.step) begin
        if (victim) begin
          pinned_q[pos_q] <= 1'b1;
          use_q[pos_q]    <= USE_BITS'(1);
        end else if (use_q[pos_q] != '0) begin
          use_q[pos_q] <= use_q[pos_q] - USE_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    hand_d = hand_q;
    if (cmd_i.step && victim) begin
      hand_d = pos_next;
    end
  end

  // tags, request latch and sweep pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_table_q <= table_id_i;
      req_page_q  <= page_index_i;
      pos_q       <= hand_start;
      if (is_req && !hit_any && empty_any) begin
        table_q[fill_idx] <= table_id_i;
        page_q[fill_idx]  <= page_index_i;
      end
    end else if (cmd_i.step) begin
      if (victim) begin
        table_q[pos_q] <= req_table_q;
        page_q[pos_q]  <= req_page_q;
      end else begin
        pos_q <= pos_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_q     <= '0;
      hit_q      <= 1'b0;
      evicted_q  <= 1'b0;
      failed_q   <= 1'b0;
      ev_table_q <= '0;
      ev_page_q  <= '0;
      if (cmd_i.step) begin
        slot_q     <= pos_q;
        evicted_q  <= 1'b1;
        ev_table_q <= table_q[pos_q];
        ev_page_q  <= page_q[pos_q];
      end else if (!is_req) begin
        slot_q <= release_slot_i;
      end else if (hit_any) begin
        slot_q <= hit_idx;
        hit_q  <= 1'b1;
      end else if (empty_any) begin
        slot_q <= fill_idx;
      end else begin
        failed_q <= 1'b1;
      end
    end
  end

  assign slot_o          = slot_q;
  assign hit_o           = hit_q;
  assign evicted_o       = evicted_q;
  assign evicted_table_o = ev_table_q;
  assign evicted_page_o  = ev_page_q;
  assign failed_o        = failed_q;

endmodule
`default_nettype wire

>>> sv/csbuf_ctrl.sv
`default_nettype none
module csbuf_ctrl import csbuf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire csbuf_stat_t stat_i,
  output csbuf_cmd_t       cmd_o
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SWEEP = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.out_load = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = !out_free;
        cmd_o.accept = in_valid_i && out_free;
        if (cmd_o.accept) begin
          if (stat_i.need_sweep) begin
            state_d = S_SWEEP;
          end else begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd_o.step = out_free;
        if (out_free && stat_i.victim) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> sv/csbuf_checker.sv
`default_nettype none
module csbuf_checker import csbuf_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_we_i,
  input wire logic [CNT_W-1:0]   cfg_wdata_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               command_i,
  input wire logic [TABLE_W-1:0] table_id_i,
  input wire logic [PAGE_W-1:0]  page_index_i,
  input wire logic [SLOT_W-1:0]  release_slot_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [SLOT_W-1:0]  slot_o,
  input wire logic               hit_o,
  input wire logic               evicted_o,
  input wire logic [TABLE_W-1:0] evicted_table_o,
  input wire logic [PAGE_W-1:0]  evicted_page_o,
  input wire logic               failed_o
);

  // result kinds exclude each other
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((hit_o && evicted_o) || (hit_o && failed_o) ||
                      (evicted_o && failed_o)))
    else $error("more than one result kind set");

  // a failed request reports slot zero and no tag
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && failed_o) |-> (slot_o == '0 && evicted_table_o == '0 &&
                                   evicted_page_o == '0))
    else $error("failed result carries slot or tag");

  // a non-eviction result carries no tag
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_o) |-> (evicted_table_o == '0 && evicted_page_o == '0))
    else $error("tag reported without eviction");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(slot_o) &&
                                      $stable(evicted_page_o)))
    else $error("stalled result changed");

endmodule

bind clock_sweep_page_buffer csbuf_checker u_csbuf_checker (.*);
`default_nettype wire

>>> tb/tb.sv
module tb import csbuf_pkg::*; ();

  // a request as it sits on the input ports
  typedef struct packed {
    logic               cmd;
    logic [TABLE_W-1:0] tab_id;
    logic [PAGE_W-1:0]  page;
    logic [SLOT_W-1:0]  rel_slot;
  } page_req_t;

  // one result as it shows on the output ports
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               evicted;
    logic [TABLE_W-1:0] ev_tab;
    logic [PAGE_W-1:0]  ev_page;
    logic               failed;
  } slot_res_t;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_MAX    = 32;
  // worst sweep: every active slot aged from a full use count, plus margin
  localparam int DRAIN_CYCLES = MAX_SLOTS * (1 << USE_BITS) + 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = CMD_REQUEST;
  logic [TABLE_W-1:0] table_id_i = '0;
  logic [PAGE_W-1:0]  page_index_i = '0;
  logic [SLOT_W-1:0]  release_slot_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SLOT_W-1:0]  slot_o;
  logic               hit_o;
  logic               evicted_o;
  logic [TABLE_W-1:0] evicted_table_o;
  logic [PAGE_W-1:0]  evicted_page_o;
  logic               failed_o;

  clock_sweep_page_buffer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .table_id_i      (table_id_i),
    .page_index_i    (page_index_i),
    .release_slot_i  (release_slot_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slot_o          (slot_o),
    .hit_o           (hit_o),
    .evicted_o       (evicted_o),
    .evicted_table_o (evicted_table_o),
    .evicted_page_o  (evicted_page_o),
    .failed_o        (failed_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the buffer state, updated as requests are taken
  logic               buf_valid  [MAX_SLOTS];
  logic [TABLE_W-1:0] buf_tab    [MAX_SLOTS];
  logic [PAGE_W-1:0]  buf_page   [MAX_SLOTS];
  logic               buf_pinned [MAX_SLOTS];
  logic [USE_BITS-1:0] buf_use   [MAX_SLOTS];
  logic [SLOT_W-1:0]  buf_hand;
  logic [CNT_W-1:0]   buf_slot_cfg;

  page_req_t req_backlog[$];       // requests not yet taken by the block
  slot_res_t slot_results_due[$];  // results predicted, not yet seen

  logic req_fire = 1'b0;           // request taken at the last rising edge
  bit   quiet_phase = 1'b0;        // no gaps and no stalls while set
  int   gap_left = 0;
  int   stall_left = 0;
  int   err_count = 0;
  int   cycle_count = 0;
  int   n_hit = 0, n_fill = 0, n_evict = 0, n_fail = 0, n_release = 0, n_cfg = 0;

  // tag pool for the random part, so that hits and evictions recur
  logic [TABLE_W-1:0] pool_tab  [POOL_MAX];
  logic [PAGE_W-1:0]  pool_page [POOL_MAX];

  // 0 behaves as one slot, anything above the slot count as the slot count
  function automatic int active_count(logic [CNT_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > MAX_SLOTS) return MAX_SLOTS;
    return int'(cfg);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_idle_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // lookup, fill, clock sweep and release on the shadow state
  function automatic slot_res_t resolve_request(page_req_t r);
    slot_res_t res;
    int        n;
    int        pos;
    bit        any_free;
    res = '0;
    n = active_count(buf_slot_cfg);
    if (r.cmd == CMD_RELEASE) begin
      // pin cleared whether or not the slot is valid or active
      buf_pinned[r.rel_slot] = 1'b0;
      res.slot = r.rel_slot;
      n_release++;
      return res;
    end
    // hit: lowest matching valid slot
    for (int i = 0; i < n; i++) begin
      if (buf_valid[i] && buf_tab[i] == r.tab_id && buf_page[i] == r.page) begin
        buf_pinned[i] = 1'b1;
        if (buf_use[i] != USE_MAX) buf_use[i]++;
        res.slot = SLOT_W'(i);
        res.hit = 1'b1;
        n_hit++;
        return res;
      end
    end
    // miss: lowest empty slot, hand stays put
    for (int i = 0; i < n; i++) begin
      if (!buf_valid[i]) begin
        buf_valid[i]  = 1'b1;
        buf_tab[i]    = r.tab_id;
        buf_page[i]   = r.page;
        buf_pinned[i] = 1'b1;
        buf_use[i]    = USE_BITS'(1);
        res.slot = SLOT_W'(i);
        n_fill++;
        return res;
      end
    end
    any_free = 1'b0;
    for (int i = 0; i < n; i++) if (!buf_pinned[i]) any_free = 1'b1;
    if (!any_free) begin
      res.failed = 1'b1;
      n_fail++;
      return res;
    end
    // sweep from the hand, aging every slot passed
    pos = (int'(buf_hand) < n) ? int'(buf_hand) : 0;
    for (int guard = 0; guard < n * (int'(USE_MAX) + 3); guard++) begin
      if (!buf_pinned[pos] && buf_use[pos] == 0) begin
        res.slot    = SLOT_W'(pos);
        res.evicted = 1'b1;
        res.ev_tab  = buf_tab[pos];
        res.ev_page = buf_page[pos];
        buf_tab[pos]    = r.tab_id;
        buf_page[pos]   = r.page;
        buf_pinned[pos] = 1'b1;
        buf_use[pos]    = USE_BITS'(1);
        buf_hand = (pos + 1 < n) ? SLOT_W'(pos + 1) : '0;
        n_evict++;
        return res;
      end
      if (buf_use[pos] != 0) buf_use[pos]--;
      pos = (pos + 1 < n) ? pos + 1 : 0;
    end
    res.failed = 1'b1;
    n_fail++;
    return res;
  endfunction

  function automatic bit field_ok(string name, logic [PAGE_W-1:0] want,
                                  logic [PAGE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // unused fields get random content so every input bit toggles
  function automatic void push_request(logic [TABLE_W-1:0] t, logic [PAGE_W-1:0] p);
    page_req_t r;
    r.cmd      = CMD_REQUEST;
    r.tab_id   = t;
    r.page     = p;
    r.rel_slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
    req_backlog.push_back(r);
  endfunction

  function automatic void push_release(logic [SLOT_W-1:0] s);
    page_req_t r;
    r.cmd      = CMD_RELEASE;
    r.tab_id   = TABLE_W'($urandom);
    r.page     = PAGE_W'($urandom);
    r.rel_slot = s;
    req_backlog.push_back(r);
  endfunction

  // every request yields a result, so an empty backlog and no result due
  // means the block is idle
  task automatic wait_idle();
    while (req_backlog.size() != 0 || slot_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_slot_count(logic [CNT_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    buf_slot_cfg = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CNT_W'($urandom);
  endtask

  // random phase: a tag pool a bit larger than the active slots, mixed
  // with pin releases that keep the sweep from running out of victims
  task automatic queue_random_phase(int count);
    int n;
    int pool_n;
    int k;
    n = active_count(buf_slot_cfg);
    pool_n = n + n / 2 + 2;
    for (int i = 0; i < pool_n; i++) begin
      pool_tab[i]  = TABLE_W'($urandom);
      pool_page[i] = PAGE_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        pool_tab[i]  = $urandom_range(0, 1) ? '1 : '0;
        pool_page[i] = $urandom_range(0, 1) ? '1 : '0;
      end
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 4) != 0) push_release(SLOT_W'($urandom_range(0, n - 1)));
        else push_release(SLOT_W'($urandom_range(0, MAX_SLOTS - 1)));
      end else if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, pool_n - 1);
        push_request(pool_tab[k], pool_page[k]);
      end else begin
        push_request(TABLE_W'($urandom), PAGE_W'($urandom));
      end
    end
  endtask

  // request driver: holds valid and payload until taken, then maybe idles
  always @(negedge clk_i) begin
    logic drive_valid;
    drive_valid = in_valid_i;
    if (rst_ni) begin
      if (req_fire) begin
        req_backlog.delete(0);
        drive_valid = 1'b0;
        gap_left = draw_idle_len();
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          drive_valid    = 1'b1;
          command_i      <= req_backlog[0].cmd;
          table_id_i     <= req_backlog[0].tab_id;
          page_index_i   <= req_backlog[0].page;
          release_slot_i <= req_backlog[0].rel_slot;
        end
      end
    end
    in_valid_i <= drive_valid;
  end

  // result stall: runs of random length, independent of out_valid_o
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left <= draw_idle_len();
    end
  end

  // monitor: check taken results, then predict for a taken request
  always @(posedge clk_i) begin
    slot_res_t got;
    slot_res_t want;
    bit        ok;
    req_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {slot_o, hit_o, evicted_o, evicted_table_o, evicted_page_o, failed_o};
        if (slot_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got slot %0h", $time,
                   got.slot);
          err_count++;
        end else begin
          want = slot_results_due.pop_front();
          ok = field_ok("slot", PAGE_W'(want.slot), PAGE_W'(got.slot));
          ok &= field_ok("hit", PAGE_W'(want.hit), PAGE_W'(got.hit));
          ok &= field_ok("evicted", PAGE_W'(want.evicted), PAGE_W'(got.evicted));
          ok &= field_ok("evicted_table", PAGE_W'(want.ev_tab), PAGE_W'(got.ev_tab));
          ok &= field_ok("evicted_page", want.ev_page, got.ev_page);
          ok &= field_ok("failed", PAGE_W'(want.failed), PAGE_W'(got.failed));
          if (!ok) err_count++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        slot_results_due.push_back(resolve_request(
          page_req_t'({command_i, table_id_i, page_index_i, release_slot_i})));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, slot_results_due.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_cfg[7];
    for (int i = 0; i < MAX_SLOTS; i++) begin
      buf_valid[i]  = 1'b0;
      buf_tab[i]    = '0;
      buf_page[i]   = '0;
      buf_pinned[i] = 1'b0;
      buf_use[i]    = '0;
    end
    buf_hand     = '0;
    buf_slot_cfg = SLOTS_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fills at the reset slot count, extreme tags, a hit
    push_request('0, '0);
    push_request('1, '1);
    push_request('0, '0);
    push_release(SLOT_W'(MAX_SLOTS - 1));  // release of a never-filled slot
    // two slots: sweep ages both, skips the pinned one, hand ends on slot 1
    set_slot_count(CNT_W'(2));
    push_release('0);
    push_request(8'd7, 16'd7);
    // slot count 0 acts as one slot, hand now beyond the active range
    set_slot_count('0);
    push_release('0);
    push_request('1, '1);
    push_request(8'd9, 16'd9);             // only slot pinned: failure
    repeat (15) push_request('1, '1);      // use count runs into saturation
    push_release('0);
    push_request(8'd9, 16'd9);             // long sweep down from full count

    // random phases, each at its own slot count
    phase_cfg = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd9, 5'd0};
    phase_cfg[4] = CNT_W'($urandom_range(2, MAX_SLOTS - 1));
    for (int p = 0; p < 7; p++) begin
      set_slot_count(phase_cfg[p]);
      quiet_phase = (p == 2);
      queue_random_phase(70);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d hits, %0d fills, %0d evictions, %0d failures, %0d releases",
             n_hit, n_fill, n_evict, n_fail, n_release);
    $display("summary: %0d slot count writes, %0d mismatches", n_cfg, err_count);
    if (err_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
